// File: design/cubic_bezier_flattener_assert.svh
`ifndef CUBIC_BEZIER_FLATTENER_ASSERT_SVH
`define CUBIC_BEZIER_FLATTENER_ASSERT_SVH
// implication check under reset
`define CBF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle check under reset
`define CBF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// File: design/cbf_pkg.sv
package cbf_pkg;
  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned DIFF_SAT = 1 << 30;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT1, ST_DIV, ST_SQRT2, ST_EMIT, ST_LAST
  } back_state_t;
endpackage

// File: design/cbf_ram.sv
module cbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/cbf_front.sv
`include "cubic_bezier_flattener_assert.svh"
// Front: takes a curve, computes the larger squared second difference and
// queues curve plus magnitude for the back end. Two-entry queue.
module cbf_front #(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [8*CW-1:0]      pts_in,
  output logic                 q_valid,
  input  logic                 q_take,
  output logic [8*CW-1:0]      q_pts,
  output logic [63:0]          q_mag
);
  localparam int DW = CW + 3;
  localparam int QW = 8 * CW + 64;
  localparam longint DIFFCLAMP = longint'(cbf_pkg::DIFF_SAT);

  // stage 1: saturated second differences
  logic            s1_valid;
  logic [8*CW-1:0] s1_pts;
  logic signed [31:0] s1_d [4];
  // stage 2: squares summed
  logic            s2_valid;
  logic [8*CW-1:0] s2_pts;
  logic [63:0]     s2_m0, s2_m1;

  logic [1:0] cnt;
  logic       wptr, rptr;
  logic       rd_pend;
  logic [QW-1:0] rdata;
  logic       out_full;
  logic [QW-1:0] out_word;
  logic       wr_en, rd_en;
  logic [1:0] in_flight;

  function automatic logic signed [31:0] sdiff(logic [CW-1:0] a, logic [CW-1:0] b,
                                               logic [CW-1:0] c);
    logic signed [DW-1:0] d;
    longint dl;
    d  = DW'(signed'(a)) - (DW'(signed'(b)) <<< 1) + DW'(signed'(c));
    dl = longint'(d);
    if (dl > DIFFCLAMP) return 32'(DIFFCLAMP);
    if (dl < -DIFFCLAMP) return 32'(-DIFFCLAMP);
    return 32'(d);
  endfunction

  function automatic logic [CW-1:0] pt(logic [8*CW-1:0] v, int k);
    return v[k*CW +: CW];
  endfunction

  // stalls: accept only while queue+pipe have room for everything in flight
  assign in_flight = 2'(s1_valid) + 2'(s2_valid);
  assign full = (3'(cnt) + 3'(in_flight) + 3'(out_full && !rd_pend)) >= 3'd2 ||
                s1_valid || s2_valid || rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= push && !full;
      s2_valid <= s1_valid;
    end
    s1_pts  <= pts_in;
    s1_d[0] <= sdiff(pt(pts_in, 0), pt(pts_in, 2), pt(pts_in, 4));
    s1_d[1] <= sdiff(pt(pts_in, 1), pt(pts_in, 3), pt(pts_in, 5));
    s1_d[2] <= sdiff(pt(pts_in, 2), pt(pts_in, 4), pt(pts_in, 6));
    s1_d[3] <= sdiff(pt(pts_in, 3), pt(pts_in, 5), pt(pts_in, 7));
    s2_pts  <= s1_pts;
    s2_m0   <= 64'(s1_d[0]) * 64'(s1_d[0]) + 64'(s1_d[1]) * 64'(s1_d[1]);
    s2_m1   <= 64'(s1_d[2]) * 64'(s1_d[2]) + 64'(s1_d[3]) * 64'(s1_d[3]);
  end

  assign wr_en = s2_valid;
  assign rd_en = (cnt != 2'd0) && !rd_pend && (!out_full || q_take);

  cbf_ram #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wptr),
    .wdata ({s2_pts, (s2_m0 > s2_m1) ? s2_m0 : s2_m1}),
    .raddr (rptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      wptr     <= 1'b0;
      rptr     <= 1'b0;
      rd_pend  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      cnt     <= cnt + 2'(wr_en) - 2'(rd_en);
      wptr    <= wptr ^ wr_en;
      rptr    <= rptr ^ rd_en;
      rd_pend <= rd_en;
      if (rd_pend) begin
        out_full <= 1'b1;
      end else if (q_take) begin
        out_full <= 1'b0;
      end
    end
    if (rd_pend) begin
      out_word <= rdata;
    end
  end

  assign q_valid = out_full;
  assign q_pts   = out_word[QW-1:64];
  assign q_mag   = out_word[63:0];

  `CBF_ASSERT_IMP(a_no_overflow, wr_en, cnt != 2'd2 || rd_en)
  `CBF_ASSERT_NXT(a_read_lands, rd_pend, out_full)
  `CBF_ASSERT_IMP(a_take_valid, q_take, out_full)
endmodule

// File: design/cbf_back.sv
`include "cubic_bezier_flattener_assert.svh"
// Back: root, then divide and root to get eps (or eps is the whole curve when
// accuracy allows), then de Casteljau points one at a time. Bit-serial root step shared by both roots.
module cbf_back #(
  parameter int CW = 24,
  parameter int MAX_SEG = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          accuracy,
  input  logic                 q_valid,
  output logic                 q_take,
  input  logic [8*CW-1:0]      q_pts,
  input  logic [63:0]          q_mag,
  output logic                 res_valid,
  input  logic                 res_take,
  output logic [CW-1:0]        res_x,
  output logic [CW-1:0]        res_y,
  output logic                 res_last
);
  localparam int EW = CW + 8;            // extended coordinate
  localparam int LW = EW + 2;
  localparam int unsigned EPS_MIN = (cbf_pkg::ONE_Q16 + MAX_SEG - 1) / MAX_SEG;
  localparam int NW = $clog2(MAX_SEG + 1);

  cbf_pkg::back_state_t state, state_next;

  logic [8*CW-1:0] pts;
  logic [63:0] rv, rr, rbit;          // isqrt working set
  logic [5:0]  step;
  logic [95:0] num;                   // divide dividend / remainder
  logic [47:0] den;
  logic [47:0] quo;
  logic [16:0] eps, t;
  logic [NW-1:0] n;
  logic [47:0] dd;
  logic        acc_ge;

  // point evaluation pipeline
  logic [2:0] ph;
  logic signed [LW-1:0] ax [2][4];
  logic signed [LW-1:0] tmp [2][3];

  logic out_full;
  logic ev_done;
  logic room, emit_done, res_load;

  assign q_take = (state == cbf_pkg::ST_IDLE) && q_valid;

  function automatic logic signed [LW-1:0] lerp(logic signed [LW-1:0] a,
                                               logic signed [LW-1:0] b,
                                               logic [16:0] tt);
    logic signed [LW+18:0] p;
    p = (LW+19)'(b - a) * signed'({2'b0, tt}) + (LW+19)'(32768);
    return a + LW'(p >>> 16);
  endfunction

  function automatic logic [CW-1:0] fin(logic signed [LW-1:0] v);
    logic signed [LW-1:0] r;
    logic signed [LW-1:0] hi;
    r  = (v + LW'(128)) >>> 8;
    hi = LW'((longint'(1) <<< (CW - 1)) - 1);
    if (r > hi) return CW'(hi);
    if (r < -hi - LW'(1)) return CW'(-hi - LW'(1));
    return CW'(r);
  endfunction

  // isqrt step shared by both roots
  logic [63:0] sq_sum;
  assign sq_sum = rr + rbit;

  assign room      = !out_full || res_take;
  assign emit_done = (t >= 17'(cbf_pkg::ONE_Q16)) || (n == NW'(MAX_SEG - 1));
  assign res_load  = room && ((state == cbf_pkg::ST_EMIT && ev_done && !emit_done) ||
                              state == cbf_pkg::ST_LAST);

  always_comb begin
    state_next = state;
    case (state)
      cbf_pkg::ST_IDLE:  if (q_valid) state_next = cbf_pkg::ST_SQRT1;
      cbf_pkg::ST_SQRT1: if (rbit == 64'd0) state_next = cbf_pkg::ST_DIV;
      cbf_pkg::ST_DIV: begin
        if (acc_ge) begin
          state_next = cbf_pkg::ST_EMIT;
        end else if (step == 6'd1) begin
          state_next = cbf_pkg::ST_SQRT2;
        end
      end
      cbf_pkg::ST_SQRT2: if (rbit == 64'd0) state_next = cbf_pkg::ST_EMIT;
      cbf_pkg::ST_EMIT:  if (emit_done) state_next = cbf_pkg::ST_LAST;
      cbf_pkg::ST_LAST:  if (room) state_next = cbf_pkg::ST_IDLE;
      default:           state_next = cbf_pkg::ST_IDLE;
    endcase
  end

  assign dd     = 48'(rr) * 48'd192;
  assign acc_ge = 48'(accuracy) >= dd;
  assign ev_done = (ph == 3'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cbf_pkg::ST_IDLE;
      out_full <= 1'b0;
      ph       <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        out_full <= 1'b1;
      end else if (res_take) begin
        out_full <= 1'b0;
      end
      case (state)
        cbf_pkg::ST_EMIT: begin
          if (!emit_done) begin
            if (ev_done) begin
              if (room) ph <= '0;
            end else begin
              ph <= ph + 3'd1;
            end
          end
        end
        cbf_pkg::ST_LAST: ;
        default: ph <= '0;
      endcase
    end

    case (state)
      cbf_pkg::ST_IDLE: begin
        pts  <= q_pts;
        rv   <= q_mag;
        rr   <= '0;
        rbit <= 64'd1 << 62;
        n    <= '0;
      end
      cbf_pkg::ST_SQRT1, cbf_pkg::ST_SQRT2: begin
        if (rbit > rv && rr == 64'd0) begin
          rbit <= rbit >> 2;
        end else if (rbit != 64'd0) begin
          if (rv >= sq_sum) begin
            rv <= rv - sq_sum;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
        end
        if (state == cbf_pkg::ST_SQRT1) begin
          num  <= {48'd0, accuracy, 32'd0};
          step <= 6'd49;
          quo  <= '0;
        end else if (rbit == 64'd0) begin
          eps <= (rr > 64'(cbf_pkg::ONE_Q16)) ? 17'(cbf_pkg::ONE_Q16) :
                 (rr < 64'(EPS_MIN)) ? 17'(EPS_MIN) : 17'(rr);
          t   <= (rr > 64'(cbf_pkg::ONE_Q16)) ? 17'(cbf_pkg::ONE_Q16) :
                 (rr < 64'(EPS_MIN)) ? 17'(EPS_MIN) : 17'(rr);
        end
      end
      cbf_pkg::ST_DIV: begin
        if (step == 6'd49) den <= dd;
        if (acc_ge) begin
          eps <= 17'(cbf_pkg::ONE_Q16);
          t   <= 17'(cbf_pkg::ONE_Q16);
        end else if (step == 6'd49) begin
          step <= step - 6'd1;
        end else begin
          // restoring division, one quotient bit per cycle, 48 bits
          if (num[94:47] >= den) begin
            num <= {num[94:47] - den, num[46:0], 1'b0};
            quo <= {quo[46:0], 1'b1};
          end else begin
            num <= {num[94:0], 1'b0};
            quo <= {quo[46:0], 1'b0};
          end
          step <= step - 6'd1;
          if (step == 6'd1) begin
            rv   <= 64'(quo[46:0]) << 1 | 64'(num[94:47] >= den);
            rr   <= '0;
            rbit <= 64'd1 << 62;
          end
        end
      end
      cbf_pkg::ST_EMIT: begin
        for (int c = 0; c < 2; c++) begin
          case (ph)
            3'd0: for (int k = 0; k < 4; k++) ax[c][k] <=
                    LW'(signed'(pts[(2*k+c)*CW +: CW])) <<< 8;
            3'd1: for (int k = 0; k < 3; k++) tmp[c][k] <= lerp(ax[c][k], ax[c][k+1], t);
            3'd2: begin
              tmp[c][0] <= lerp(tmp[c][0], tmp[c][1], t);
              tmp[c][1] <= lerp(tmp[c][1], tmp[c][2], t);
            end
            3'd3: tmp[c][2] <= lerp(tmp[c][0], tmp[c][1], t);
            default: ;
          endcase
        end
        if (res_load) begin
          res_x    <= fin(lerp(tmp[0][0], tmp[0][1], t));
          res_y    <= fin(lerp(tmp[1][0], tmp[1][1], t));
          res_last <= 1'b0;
          t        <= t + eps;
          n        <= n + NW'(1);
        end
      end
      cbf_pkg::ST_LAST: begin
        if (room) begin
          res_x    <= pts[6*CW +: CW];
          res_y    <= pts[7*CW +: CW];
          res_last <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_valid = out_full;

  `CBF_ASSERT_IMP(a_take_idle, q_take, state == cbf_pkg::ST_IDLE)
  `CBF_ASSERT_NXT(a_word_held, res_valid && !res_take,
                  res_valid && $stable({res_x, res_y, res_last}))
  `CBF_ASSERT_IMP(a_count_bound, state == cbf_pkg::ST_EMIT, n <= NW'(MAX_SEG - 1))
endmodule

// File: design/cubic_bezier_flattener.sv
// channel | handshake        | words
// curve   | push / full      | start, ctrl1, ctrl2, end (x,y)
// point   | pop / empty      | point_x, point_y, last_point
// config  | accuracy_we      | accuracy
// Front end takes no curve while one is still in its difference or square stage; 2-word queue.
// Back end per curve: take, root, divide, root (or take, root and the divide check
// alone when the step is the whole curve), then one point at a time, end point last:
// up to 64 words. The front end preloads the next curve meanwhile.
// rst is synchronous, full is high during it; a full point register stalls evaluation.
module cubic_bezier_flattener #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_WIDTH-1:0] start_x,
  input  logic [COORD_WIDTH-1:0] start_y,
  input  logic [COORD_WIDTH-1:0] ctrl1_x,
  input  logic [COORD_WIDTH-1:0] ctrl1_y,
  input  logic [COORD_WIDTH-1:0] ctrl2_x,
  input  logic [COORD_WIDTH-1:0] ctrl2_y,
  input  logic [COORD_WIDTH-1:0] end_x,
  input  logic [COORD_WIDTH-1:0] end_y,
  output logic                   empty,
  input  logic                   pop,
  output logic [COORD_WIDTH-1:0] point_x,
  output logic [COORD_WIDTH-1:0] point_y,
  output logic                   last_point,
  input  logic                   accuracy_we,
  input  logic [15:0]            accuracy_wdata
);
  logic [15:0] accuracy;
  logic q_valid, q_take;
  logic [8*COORD_WIDTH-1:0] q_pts;
  logic [63:0] q_mag;
  logic res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      accuracy <= 16'd655;
    end else if (accuracy_we) begin
      accuracy <= accuracy_wdata;
    end
  end

  cbf_front #(.CW(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .pts_in({end_y, end_x, ctrl2_y, ctrl2_x, ctrl1_y, ctrl1_x, start_y, start_x}),
    .q_valid(q_valid), .q_take(q_take), .q_pts(q_pts), .q_mag(q_mag)
  );

  cbf_back #(.CW(COORD_WIDTH), .MAX_SEG(MAX_SEGMENTS)) u_back (
    .clk(clk), .rst(rst), .accuracy(accuracy),
    .q_valid(q_valid), .q_take(q_take), .q_pts(q_pts), .q_mag(q_mag),
    .res_valid(res_valid), .res_take(pop && res_valid),
    .res_x(point_x), .res_y(point_y), .res_last(last_point)
  );

  assign empty = !res_valid;
endmodule
